>>> hw/rtl/stt_pkg.sv
// Shared types and constants for the streaming source tokenizer.
// No dependencies; every other file imports this package.
`default_nettype none

package stt_pkg;

  // Default depth of the result-group queue between front and back.
  localparam int unsigned QueueDepth = 4;

  // Token kind codes.
  localparam logic [4:0] KindEof     = 5'd0;
  localparam logic [4:0] KindLParen  = 5'd1;
  localparam logic [4:0] KindRParen  = 5'd2;
  localparam logic [4:0] KindLBrack  = 5'd3;
  localparam logic [4:0] KindRBrack  = 5'd4;
  localparam logic [4:0] KindLBrace  = 5'd5;
  localparam logic [4:0] KindRBrace  = 5'd6;
  localparam logic [4:0] KindSemi    = 5'd7;
  localparam logic [4:0] KindPlus    = 5'd8;
  localparam logic [4:0] KindMinus   = 5'd9;
  localparam logic [4:0] KindStar    = 5'd10;
  localparam logic [4:0] KindDiv     = 5'd11;
  localparam logic [4:0] KindAssign  = 5'd12;
  localparam logic [4:0] KindLess    = 5'd13;
  localparam logic [4:0] KindBang    = 5'd14;
  localparam logic [4:0] KindString  = 5'd15;
  localparam logic [4:0] KindIdent   = 5'd16;
  localparam logic [4:0] KindIf      = 5'd17;
  localparam logic [4:0] KindWhile   = 5'd18;
  localparam logic [4:0] KindFor     = 5'd19;
  localparam logic [4:0] KindReturn  = 5'd20;
  localparam logic [4:0] KindBool    = 5'd21;
  localparam logic [4:0] KindInt     = 5'd22;
  localparam logic [4:0] KindFloat   = 5'd23;
  localparam logic [4:0] KindUnknown = 5'd24;

  // Keywords as right-aligned byte strings, first byte highest.
  localparam logic [47:0] KwIf     = 48'h0000_0000_6966;
  localparam logic [47:0] KwWhile  = 48'h0077_6869_6c65;
  localparam logic [47:0] KwFor    = 48'h0000_0066_6f72;
  localparam logic [47:0] KwReturn = 48'h7265_7475_726e;
  localparam logic [47:0] KwTrue   = 48'h0000_7472_7565;
  localparam logic [47:0] KwFalse  = 48'h0066_616c_7365;

  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChDot   = 8'h2e;

  // One result beat.
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] value;
    logic       byte_valid;
    logic       done;
  } res_t;

  // All results caused by one input byte, in order from slot 0.
  typedef struct packed {
    logic [1:0]       count;
    res_t [2:0]       res;
  } group_t;

endpackage

`default_nettype wire

>>> hw/rtl/stt_front.sv
// Front part of the tokenizer: scanner state and classification of each byte.
// Depends on stt_pkg; produces one result group per accepted byte that has results.
`default_nettype none

module stt_front
  import stt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output group_t          q_data_o
);

  typedef enum logic [7:0] {
    ModeIdle      = 8'b0000_0001,
    ModeSlash     = 8'b0000_0010,
    ModeLine      = 8'b0000_0100,
    ModeBlock     = 8'b0000_1000,
    ModeBlockStar = 8'b0001_0000,
    ModeString    = 8'b0010_0000,
    ModeIdent     = 8'b0100_0000,
    ModeNumber    = 8'b1000_0000
  } scan_mode_e;

  scan_mode_e  mode_q, mode_d;
  logic [47:0] prefix_q, prefix_d;
  logic [2:0]  len_q, len_d;
  logic [1:0]  dots_q, dots_d;
  logic        prev_dot_q, prev_dot_d;
  logic        nz_q, nz_d;
  logic        frac_q, frac_d;

  logic        accept;
  logic [7:0]  c;
  group_t      grp;

  function automatic logic is_space(input logic [7:0] ch);
    return ch == 8'h20 || ch == 8'h09 || ch == 8'h0c || ch == 8'h0b ||
           ch == 8'h0a || ch == 8'h0d;
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] ch);
    logic [4:0] k;
    case (ch)
      8'h28:   k = KindLParen;
      8'h29:   k = KindRParen;
      8'h5b:   k = KindLBrack;
      8'h5d:   k = KindRBrack;
      8'h7b:   k = KindLBrace;
      8'h7d:   k = KindRBrace;
      8'h3b:   k = KindSemi;
      8'h2b:   k = KindPlus;
      8'h2d:   k = KindMinus;
      8'h2a:   k = KindStar;
      8'h3d:   k = KindAssign;
      8'h3c:   k = KindLess;
      8'h21:   k = KindBang;
      default: k = KindEof;
    endcase
    return k;
  endfunction

  function automatic res_t done_res(input logic [4:0] kind);
    res_t r;
    r.kind       = kind;
    r.value      = 8'h00;
    r.byte_valid = 1'b0;
    r.done       = 1'b1;
    return r;
  endfunction

  function automatic res_t byte_res(input logic [7:0] value);
    res_t r;
    r.kind       = KindEof;
    r.value      = value;
    r.byte_valid = 1'b1;
    r.done       = 1'b0;
    return r;
  endfunction

  assign c          = char_byte_i;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    logic [1:0] n;
    logic       do_start;
    logic [4:0] ident_k;
    logic [4:0] num_k;
    mode_d     = mode_q;
    prefix_d   = prefix_q;
    len_d      = len_q;
    dots_d     = dots_q;
    prev_dot_d = prev_dot_q;
    nz_d       = nz_q;
    frac_d     = frac_q;
    grp        = '0;
    n          = 2'd0;
    do_start   = 1'b0;

    if (len_q == 3'd2 && prefix_q == KwIf) begin
      ident_k = KindIf;
    end else if (len_q == 3'd5 && prefix_q == KwWhile) begin
      ident_k = KindWhile;
    end else if (len_q == 3'd3 && prefix_q == KwFor) begin
      ident_k = KindFor;
    end else if (len_q == 3'd6 && prefix_q == KwReturn) begin
      ident_k = KindReturn;
    end else if ((len_q == 3'd4 && prefix_q == KwTrue) ||
                 (len_q == 3'd5 && prefix_q == KwFalse)) begin
      ident_k = KindBool;
    end else begin
      ident_k = KindIdent;
    end

    if (dots_q > 2'd1) begin
      num_k = KindUnknown;
    end else if (dots_q == 2'd1) begin
      num_k = KindFloat;
    end else begin
      num_k = KindInt;
    end

    case (mode_q)
      ModeSlash: begin
        if (c == 8'h2f) begin
          mode_d = ModeLine;
        end else if (c == 8'h2a) begin
          mode_d = ModeBlock;
        end else begin
          grp.res[n] = done_res(KindDiv);
          n = n + 2'd1;
          do_start = 1'b1;
        end
      end
      ModeLine: begin
        if (c == 8'h00) begin
          do_start = 1'b1;
        end else if (c == 8'h0a || c == 8'h0d) begin
          mode_d = ModeIdle;
        end
      end
      ModeBlock: begin
        if (c == 8'h00) begin
          do_start = 1'b1;
        end else if (c == 8'h2a) begin
          mode_d = ModeBlockStar;
        end
      end
      ModeBlockStar: begin
        if (c == 8'h00) begin
          do_start = 1'b1;
        end else if (c == 8'h2f) begin
          mode_d = ModeIdle;
        end else if (c != 8'h2a) begin
          mode_d = ModeBlock;
        end
      end
      ModeString: begin
        if (c == 8'h00) begin
          grp.res[n] = done_res(KindUnknown);
          n = n + 2'd1;
          do_start = 1'b1;
        end else if (c == 8'h22) begin
          grp.res[n] = done_res(KindString);
          n = n + 2'd1;
          mode_d = ModeIdle;
        end else begin
          grp.res[n] = byte_res(c);
          n = n + 2'd1;
        end
      end
      ModeIdent: begin
        if (is_alpha(c) || is_digit(c) || c == ChUnder) begin
          if (len_q < 3'd6) begin
            prefix_d = {prefix_q[39:0], c};
          end
          if (len_q < 3'd7) begin
            len_d = len_q + 3'd1;
          end
          grp.res[n] = byte_res(c);
          n = n + 2'd1;
        end else begin
          grp.res[n] = done_res(ident_k);
          n = n + 2'd1;
          do_start = 1'b1;
        end
      end
      ModeNumber: begin
        if (is_digit(c)) begin
          if (frac_q || nz_q || c != 8'h30) begin
            if (!frac_q) begin
              nz_d = 1'b1;
            end
            grp.res[n] = byte_res(c);
            n = n + 2'd1;
          end
          prev_dot_d = 1'b0;
        end else if (c == ChDot && !prev_dot_q) begin
          if (!frac_q && !nz_q) begin
            grp.res[n] = byte_res(8'h30);
            n = n + 2'd1;
          end
          frac_d = 1'b1;
          if (dots_q < 2'd3) begin
            dots_d = dots_q + 2'd1;
          end
          prev_dot_d = 1'b1;
          grp.res[n] = byte_res(ChDot);
          n = n + 2'd1;
        end else begin
          if (!frac_q && !nz_q) begin
            grp.res[n] = byte_res(8'h30);
            n = n + 2'd1;
          end
          grp.res[n] = done_res(num_k);
          n = n + 2'd1;
          do_start = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // Start of a new token; always the last step for this byte.
    if (do_start) begin
      mode_d = ModeIdle;
      if (is_space(c)) begin
        mode_d = ModeIdle;
      end else if (c == 8'h00) begin
        grp.res[n] = done_res(KindEof);
        n = n + 2'd1;
      end else if (c == 8'h2f) begin
        mode_d = ModeSlash;
      end else if (c == 8'h22) begin
        mode_d = ModeString;
      end else if (punct_kind(c) != KindEof) begin
        grp.res[n] = done_res(punct_kind(c));
        n = n + 2'd1;
      end else if (is_alpha(c)) begin
        mode_d   = ModeIdent;
        prefix_d = {40'd0, c};
        len_d    = 3'd1;
        grp.res[n] = byte_res(c);
        n = n + 2'd1;
      end else if (is_digit(c)) begin
        mode_d     = ModeNumber;
        dots_d     = 2'd0;
        prev_dot_d = 1'b0;
        frac_d     = 1'b0;
        nz_d       = (c != 8'h30);
        if (c != 8'h30) begin
          grp.res[n] = byte_res(c);
          n = n + 2'd1;
        end
      end else begin
        grp.res[n] = done_res(KindUnknown);
        grp.res[n].value      = c;
        grp.res[n].byte_valid = 1'b1;
        n = n + 2'd1;
      end
    end
    grp.count = n;
  end

  assign q_push_o = accept && (grp.count != 2'd0);
  assign q_data_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeIdle;
      prefix_q   <= '0;
      len_q      <= '0;
      dots_q     <= '0;
      prev_dot_q <= 1'b0;
      nz_q       <= 1'b0;
      frac_q     <= 1'b0;
    end else if (accept) begin
      mode_q     <= mode_d;
      prefix_q   <= prefix_d;
      len_q      <= len_d;
      dots_q     <= dots_d;
      prev_dot_q <= prev_dot_d;
      nz_q       <= nz_d;
      frac_q     <= frac_d;
    end
  end

  // A dot can only follow a digit inside a number, so it implies a fraction.
  a_prev_dot_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_dot_q |-> frac_q)
    else $error("previous dot without fraction");

  // Comment modes never produce a result except at end of text.
  a_comment_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_q == ModeLine || mode_q == ModeBlock || mode_q == ModeBlockStar)
     && c != 8'h00) |-> !q_push_o)
    else $error("comment byte produced a result");

  // The state only moves when a byte is taken.
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(mode_q))
    else $error("scan mode changed without input");

endmodule

`default_nettype wire

>>> hw/rtl/stt_queue.sv
// Short queue of result groups between the scanner and the output sequencer.
// Depends on stt_pkg for the group type.
`default_nettype none

module stt_queue
  import stt_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  group_t      data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output group_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  group_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_empty_pointers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (rd_q == wr_q))
    else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

>>> hw/rtl/stt_back.sv
// Back part of the tokenizer: plays out one result group a beat at a time.
// Depends on stt_pkg; reads the head of the group queue.
`default_nettype none

module stt_back
  import stt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_empty_i,
  input  group_t          q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [4:0]      token_kind_o,
  output logic [7:0]      value_byte_o,
  output logic            byte_valid_o,
  output logic            token_done_o,
  output logic            last_result_o
);

  logic [1:0] idx_q, idx_d;
  res_t       cur;
  logic       fire;
  logic       last;

  always_comb begin
    case (idx_q)
      2'd0:    cur = q_data_i.res[0];
      2'd1:    cur = q_data_i.res[1];
      2'd2:    cur = q_data_i.res[2];
      default: cur = q_data_i.res[0];
    endcase
  end

  assign out_valid_o   = !q_empty_i;
  assign fire          = out_valid_o && !out_stall_i;
  assign last          = (idx_q + 2'd1) == q_data_i.count;
  assign q_pop_o       = fire && last;
  assign idx_d         = q_pop_o ? 2'd0 : (fire ? idx_q + 2'd1 : idx_q);

  assign token_kind_o  = cur.kind;
  assign value_byte_o  = cur.value;
  assign byte_valid_o  = cur.byte_valid;
  assign token_done_o  = cur.done;
  assign last_result_o = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < q_data_i.count))
    else $error("result index beyond group");

  a_idx_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (idx_q == 2'd0))
    else $error("index not rewound after group");

  a_idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty_i |-> (idx_q == 2'd0))
    else $error("index set with nothing queued");

endmodule

`default_nettype wire

>>> hw/rtl/streaming_source_tokenizer.sv
// Top level of the streaming source tokenizer.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    char_byte_i
// out      output     out_valid_o / out_stall_i  token_kind_o, value_byte_o,
//                                                byte_valid_o, token_done_o,
//                                                last_result_o
//
// The scanner takes one source byte per cycle and turns it in the same cycle
// into a group of zero to three results, and writes each non-empty group
// into a queue of QueueDepth groups. The output sequencer sends one result
// per cycle, so a byte with n results takes n output beats. Input stalls
// only while the queue is full; output stalls back up into the queue.
// Reset puts the scanner in its idle mode with all token state cleared and
// empties the queue; no clearing pass is needed.

module streaming_source_tokenizer
  import stt_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [4:0]      token_kind_o,
  output logic [7:0]      value_byte_o,
  output logic            byte_valid_o,
  output logic            token_done_o,
  output logic            last_result_o
);

  // Result groups flow from the scanner through the queue to the sequencer.
  group_t push_data;
  group_t head_data;
  logic   push;
  logic   full;
  logic   pop;
  logic   empty;

  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_byte_i (char_byte_i),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_data_o    (push_data)
  );

  stt_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_data)
  );

  stt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (empty),
    .q_data_i      (head_data),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .value_byte_o  (value_byte_o),
    .byte_valid_o  (byte_valid_o),
    .token_done_o  (token_done_o),
    .last_result_o (last_result_o)
  );

endmodule

`default_nettype wire

>>> dv/stt_tb_pkg.sv
// Scoreboard for the streaming source tokenizer bench: a byte-level token
// predictor and an in-order result checker. Depends on stt_pkg for kind codes.
package stt_tb_pkg;
  import stt_pkg::*;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChVtab    = 8'h0b;
  localparam logic [7:0] ChFeed    = 8'h0c;
  localparam logic [7:0] ChReturn  = 8'h0d;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChStar    = 8'h2a;
  localparam logic [7:0] ChSlash   = 8'h2f;
  localparam logic [7:0] ChZero    = 8'h30;

  localparam logic [47:0] WordIf     = "if";
  localparam logic [47:0] WordWhile  = "while";
  localparam logic [47:0] WordFor    = "for";
  localparam logic [47:0] WordReturn = "return";
  localparam logic [47:0] WordTrue   = "true";
  localparam logic [47:0] WordFalse  = "false";

  typedef enum logic [3:0] {
    ScanIdle, ScanSlash, ScanLine, ScanBlock, ScanBlockStar,
    ScanString, ScanIdent, ScanNumber
  } scan_mode_e;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] value;
    logic       byte_valid;
    logic       done;
    logic       last;
  } token_beat_t;

  class token_scoreboard;
    scan_mode_e  scan_mode;
    logic [47:0] word_prefix;
    logic [2:0]  word_length;
    logic [1:0]  dot_tally;
    bit          previous_dot;
    bit          nonzero_seen;
    bit          in_fraction;
    token_beat_t expected_beats[$];
    int          failures;

    function new();
      scan_mode       = ScanIdle;
      word_prefix     = '0;
      word_length     = '0;
      dot_tally       = '0;
      previous_dot    = 1'b0;
      nonzero_seen    = 1'b0;
      in_fraction     = 1'b0;
      failures        = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function bit is_space(logic [7:0] c);
      return c == ChSpace || c == ChTab || c == ChFeed || c == ChVtab ||
             c == ChNewline || c == ChReturn;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function logic [4:0] punct_kind(logic [7:0] c);
      case (c)
        "(":     return KindLParen;
        ")":     return KindRParen;
        "[":     return KindLBrack;
        "]":     return KindRBrack;
        "{":     return KindLBrace;
        "}":     return KindRBrace;
        ";":     return KindSemi;
        "+":     return KindPlus;
        "-":     return KindMinus;
        "*":     return KindStar;
        "=":     return KindAssign;
        "<":     return KindLess;
        "!":     return KindBang;
        default: return KindEof;
      endcase
    endfunction

    function logic [4:0] word_kind();
      if (word_length == 3'd2 && word_prefix == WordIf) return KindIf;
      if (word_length == 3'd5 && word_prefix == WordWhile) return KindWhile;
      if (word_length == 3'd3 && word_prefix == WordFor) return KindFor;
      if (word_length == 3'd6 && word_prefix == WordReturn) return KindReturn;
      if (word_length == 3'd4 && word_prefix == WordTrue) return KindBool;
      if (word_length == 3'd5 && word_prefix == WordFalse) return KindBool;
      return KindIdent;
    endfunction

    function void add_beat(logic [4:0] kind, logic [7:0] value, bit bv, bit done);
      token_beat_t t;
      t.kind       = done ? kind : 5'd0;
      t.value      = bv ? value : 8'd0;
      t.byte_valid = bv;
      t.done       = done;
      t.last       = 1'b0;
      expected_beats.insert(expected_beats.size(), t);
    endfunction

    // Decide what a byte starts when no token is open.
    function void begin_token(logic [7:0] c);
      logic [4:0] k;
      scan_mode = ScanIdle;
      k = punct_kind(c);
      if (is_space(c)) return;
      if (c == ChNul) begin
        add_beat(KindEof, 8'd0, 1'b0, 1'b1);
      end else if (c == ChSlash) begin
        scan_mode = ScanSlash;
      end else if (c == ChQuote) begin
        scan_mode = ScanString;
      end else if (k != KindEof) begin
        add_beat(k, 8'd0, 1'b0, 1'b1);
      end else if (is_alpha(c)) begin
        scan_mode   = ScanIdent;
        word_prefix = {40'd0, c};
        word_length = 3'd1;
        add_beat(KindEof, c, 1'b1, 1'b0);
      end else if (is_digit(c)) begin
        scan_mode    = ScanNumber;
        dot_tally    = '0;
        previous_dot = 1'b0;
        in_fraction  = 1'b0;
        nonzero_seen = (c != ChZero);
        if (nonzero_seen) add_beat(KindEof, c, 1'b1, 1'b0);
      end else begin
        add_beat(KindUnknown, c, 1'b1, 1'b1);
      end
    endfunction

    function void note_char(logic [7:0] c);
      int          first;
      logic [4:0]  k;
      token_beat_t t;
      first = expected_beats.size();
      case (scan_mode)
        ScanSlash: begin
          if (c == ChSlash) scan_mode = ScanLine;
          else if (c == ChStar) scan_mode = ScanBlock;
          else begin
            add_beat(KindDiv, 8'd0, 1'b0, 1'b1);
            begin_token(c);
          end
        end
        ScanLine: begin
          if (c == ChNul) begin_token(c);
          else if (c == ChNewline || c == ChReturn) scan_mode = ScanIdle;
        end
        ScanBlock: begin
          if (c == ChNul) begin_token(c);
          else if (c == ChStar) scan_mode = ScanBlockStar;
        end
        ScanBlockStar: begin
          if (c == ChNul) begin_token(c);
          else if (c == ChSlash) scan_mode = ScanIdle;
          else if (c != ChStar) scan_mode = ScanBlock;
        end
        ScanString: begin
          if (c == ChNul) begin
            add_beat(KindUnknown, 8'd0, 1'b0, 1'b1);
            begin_token(c);
          end else if (c == ChQuote) begin
            add_beat(KindString, 8'd0, 1'b0, 1'b1);
            scan_mode = ScanIdle;
          end else begin
            add_beat(KindEof, c, 1'b1, 1'b0);
          end
        end
        ScanIdent: begin
          if (is_alpha(c) || is_digit(c) || c == ChUnder) begin
            if (word_length < 3'd6) word_prefix = {word_prefix[39:0], c};
            if (word_length < 3'd7) word_length = word_length + 3'd1;
            add_beat(KindEof, c, 1'b1, 1'b0);
          end else begin
            add_beat(word_kind(), 8'd0, 1'b0, 1'b1);
            begin_token(c);
          end
        end
        ScanNumber: begin
          if (is_digit(c)) begin
            if (in_fraction || nonzero_seen || c != ChZero) begin
              if (!in_fraction) nonzero_seen = 1'b1;
              add_beat(KindEof, c, 1'b1, 1'b0);
            end
            previous_dot = 1'b0;
          end else if (c == ChDot && !previous_dot) begin
            if (!in_fraction && !nonzero_seen) add_beat(KindEof, ChZero, 1'b1, 1'b0);
            in_fraction = 1'b1;
            if (dot_tally < 2'd3) dot_tally = dot_tally + 2'd1;
            previous_dot = 1'b1;
            add_beat(KindEof, c, 1'b1, 1'b0);
          end else begin
            k = (dot_tally > 2'd1) ? KindUnknown : (dot_tally == 2'd1) ? KindFloat : KindInt;
            if (!in_fraction && !nonzero_seen) add_beat(KindEof, ChZero, 1'b1, 1'b0);
            add_beat(k, 8'd0, 1'b0, 1'b1);
            begin_token(c);
          end
        end
        default: begin_token(c);
      endcase
      if (expected_beats.size() > first) begin
        t = expected_beats[expected_beats.size() - 1];
        t.last = 1'b1;
        expected_beats[expected_beats.size() - 1] = t;
      end
    endfunction

    function void report(string what, token_beat_t want, token_beat_t seen);
      failures++;
      if (failures <= 10)
        $display({"%s: want kind %0d value %02h bv %0b done %0b last %0b, ",
                  "got kind %0d value %02h bv %0b done %0b last %0b"},
                 what, want.kind, want.value, want.byte_valid, want.done, want.last,
                 seen.kind, seen.value, seen.byte_valid, seen.done, seen.last);
    endfunction

    function void check_beat(token_beat_t seen);
      token_beat_t want;
      if (expected_beats.size() == 0) begin
        report("unexpected result beat", '0, seen);
        return;
      end
      want = expected_beats.pop_front();
      if (seen !== want) report("result beat mismatch", want, seen);
    endfunction
  endclass

endpackage

>>> dv/streaming_source_tokenizer_tb.sv
// Self-checking bench for streaming_source_tokenizer: directed and random
// source text, random idling on both channels. Depends on stt_pkg, stt_tb_pkg.
module streaming_source_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;
  import stt_tb_pkg::*;

  // The random part stops once this many further input bytes have been sent.
  localparam int RandomItemGoal = 440;
  // Length of the long receiver hold-off that fills the internal queue.
  localparam int HoldCycles     = 80;
  // Quiet cycles after the last expected beat, so a stray beat is still seen.
  localparam int SettleCycles   = 16;
  // Worst run is far below this: ~520 bytes, 3 beats each, heavy stalls.
  localparam int CycleLimit     = 200000;
  // Sections of the random part that carry the two pressure scenarios.
  localparam int HoldSection    = 4;
  localparam int DrainSection   = 8;

  localparam logic [7:0] Blanks [6] = '{ChSpace, ChTab, ChVtab, ChFeed, ChNewline, ChReturn};
  localparam string KeywordList [6] = '{"if", "while", "for", "return", "true", "false"};
  localparam string PunctChars      = "()[]{};+-*=<!/";

  typedef enum int {StallNone, StallLight, StallToggle, StallHeavy} stall_pattern_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [4:0] token_kind_o;
  logic [7:0] value_byte_o;
  logic       byte_valid_o;
  logic       token_done_o;
  logic       last_result_o;

  token_scoreboard token_sb;
  logic [7:0]      source_text[$];
  int              hold_token  = 0;
  int              cycle_count = 0;
  int              chars_sent  = 0;
  token_beat_t     seen_beat;

  streaming_source_tokenizer u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .char_byte_i,
    .out_valid_o,
    .out_stall_i,
    .token_kind_o,
    .value_byte_o,
    .byte_valid_o,
    .token_done_o,
    .last_result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("streaming_source_tokenizer verification failed");
      $finish;
    end
  end

  // Monitor. Both channels are sampled at the rising edge, which sees the
  // values from before the edge, so the input beat of this edge is noted
  // before the output beat of the same edge is checked. That keeps the order
  // right even if the block could pass a result through in the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) token_sb.note_char(char_byte_i);
      if (out_valid_o && !out_stall_i) begin
        seen_beat.kind       = token_kind_o;
        seen_beat.value      = value_byte_o;
        seen_beat.byte_valid = byte_valid_o;
        seen_beat.done       = token_done_o;
        seen_beat.last       = last_result_o;
        token_sb.check_beat(seen_beat);
      end
    end
  end

  // Receiver. It stalls in segments of random length, each with its own
  // pattern: none at all, light, toggling or heavy. When the stimulus bumps
  // hold_token it holds off until a countdown from HoldCycles runs out, so that
  // the queue inside the block fills and the input side has to stall.
  initial begin : receiver
    int             hold_left;
    int             seg_left;
    int             hold_seen;
    stall_pattern_e pattern;
    hold_left   = 0;
    seg_left    = 0;
    hold_seen   = 0;
    pattern     = StallNone;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      if (seg_left == 0) begin
        pattern  = stall_pattern_e'($urandom_range(0, 3));
        seg_left = $urandom_range(4, 60);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        seg_left--;
        case (pattern)
          StallLight:  out_stall_i <= ($urandom_range(0, 3) == 0);
          StallToggle: out_stall_i <= seg_left[0];
          StallHeavy:  out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= 1'b0;
        endcase
      end
      @(posedge clk_i);
    end
  end

  // Offer one byte and keep it steady until the block takes it.
  task automatic send_char(input logic [7:0] c);
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
  endtask

  // Send the queued text in bursts, with gaps after some of them; a steady stream
  // has no gaps. The channel is set idle at the end and an edge is awaited,
  // so a following send never drives valid twice in the same time step.
  task automatic stream_text(input bit steady);
    int burst;
    while (source_text.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && source_text.size() != 0) begin
        send_char(source_text.pop_front());
        burst--;
      end
      if (!steady && $urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (token_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Append one byte to the text waiting to be sent.
  function automatic void append_char(logic [7:0] b);
    source_text.insert(source_text.size(), b);
  endfunction

  function automatic void push_string(string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endfunction

  function automatic logic [7:0] letter();
    return 8'(($urandom_range(0, 1) != 0 ? "A" : "a") + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] digit();
    return 8'(ChZero + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 5))
      0:       return ChUnder;
      1, 2:    return digit();
      default: return letter();
    endcase
  endfunction

  // Append one random piece of source text. Most pieces are well-formed
  // tokens, comments and blanks with random content; a few are stray bytes,
  // end-of-text markers and unterminated constructs.
  function automatic void add_fragment();
    logic [7:0] b;
    int         zeros;
    int         dots;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        repeat ($urandom_range(1, 3)) append_char(Blanks[$urandom_range(0, 5)]);
      end
      3, 4, 5, 6: begin
        // Keywords, sometimes with a trailing character that spoils them,
        // and plain identifiers, some long enough to saturate the length.
        if ($urandom_range(0, 2) == 0) begin
          push_string(KeywordList[$urandom_range(0, 5)]);
          if ($urandom_range(0, 3) == 0) append_char(word_char());
        end else begin
          append_char(letter());
          repeat ($urandom_range(0, ($urandom_range(0, 3) == 0) ? 10 : 4))
            append_char(word_char());
        end
      end
      7, 8, 9: begin
        // Leading zeros, integer digits, then zero to three dots, some of
        // them doubled so that the second dot ends the number.
        zeros = $urandom_range(0, 3);
        repeat (zeros) append_char(ChZero);
        repeat ($urandom_range(zeros == 0 ? 1 : 0, 3)) append_char(digit());
        case ($urandom_range(0, 9))
          0, 1, 2, 3: dots = 0;
          4, 5, 6:    dots = 1;
          7, 8:       dots = 2;
          default:    dots = 3;
        endcase
        repeat (dots) begin
          append_char(ChDot);
          if ($urandom_range(0, 5) == 0) append_char(ChDot);
          repeat ($urandom_range(0, 2)) append_char(digit());
        end
      end
      10, 11: begin
        append_char(ChQuote);
        repeat ($urandom_range(0, 6)) begin
          b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                          : 8'($urandom_range(32, 126));
          append_char(b == ChQuote ? ChSpace : b);
        end
        // Now and then the text ends inside the string.
        append_char($urandom_range(0, 7) != 0 ? ChQuote : ChNul);
      end
      12: begin
        push_string("//");
        repeat ($urandom_range(0, 8)) begin
          b = 8'($urandom_range(1, 255));
          append_char((b == ChNewline || b == ChReturn) ? ChStar : b);
        end
        case ($urandom_range(0, 4))
          0:       append_char(ChNul);
          1:       append_char(ChReturn);
          default: append_char(ChNewline);
        endcase
      end
      13: begin
        // A slash right after the opener must not close the comment.
        push_string("/*");
        if ($urandom_range(0, 3) == 0) append_char(ChSlash);
        repeat ($urandom_range(0, 8))
          append_char(($urandom_range(0, 2) == 0) ? ChStar : 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 7) == 0) append_char(ChNul);
        else push_string(($urandom_range(0, 1) != 0) ? "*/" : "**/");
      end
      14, 15, 16: append_char(PunctChars[$urandom_range(0, PunctChars.len() - 1)]);
      17:         append_char(8'($urandom_range(1, 255)));
      18:         append_char(ChNul);
      default: begin
        // Division between two operands, no blanks around the slash.
        append_char(letter());
        append_char(ChSlash);
        append_char(digit());
      end
    endcase
    if ($urandom_range(0, 1) == 0) append_char(Blanks[$urandom_range(0, 5)]);
  endfunction

  initial begin : stimulus
    int section;
    int item_goal;
    token_sb    = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_byte_i = 8'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed text: every single-character token, a division, a number
    // cut off by the end of text, the two byte extremes as unknown bytes,
    // a string cut off by the end of text, and a comment left open.
    push_string("()[]{};+-*=<!/9");
    append_char(ChNul);
    append_char(8'hff);
    append_char(8'h01);
    append_char(ChQuote);
    append_char(ChNul);
    push_string("/*");
    append_char(ChNul);
    stream_text(1'b0);
    wait_drained();

    // Random text, one section at a time. One section runs without gaps
    // while the receiver holds off, so the block backs up into its input.
    // After another the sender waits until every expected beat has come.
    item_goal = chars_sent + RandomItemGoal;
    section   = 0;
    while (chars_sent < item_goal) begin
      section++;
      while (source_text.size() < 32) add_fragment();
      if (section == HoldSection) begin
        while (source_text.size() < 64) add_fragment();
        hold_token <= hold_token + 1;
        stream_text(1'b1);
      end else begin
        stream_text(1'b0);
      end
      if (section == DrainSection) wait_drained();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (token_sb.failures == 0 && token_sb.pending() == 0) begin
      $display("streaming_source_tokenizer verification clean");
    end else begin
      $display("streaming_source_tokenizer verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_front.sv
hw/rtl/stt_queue.sv
hw/rtl/stt_back.sv
hw/rtl/streaming_source_tokenizer.sv
dv/stt_tb_pkg.sv
dv/streaming_source_tokenizer_tb.sv
